### src/dpe_pkg.sv
// ----------------------------------------------------------------------------
// dpe_pkg: shared types and constants of the diffusion profile evaluator
// Payload structs, fixed-point constants and pipeline depths.
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CHANNELS      = 3;
  localparam int EXP_TERMS     = 10;
  localparam int EXP_SQUARINGS = 8;
  localparam int A_QBITS       = 17;
  localparam int RD_QBITS      = 32;
  localparam int EXP_LAT       = 3 * EXP_TERMS + EXP_SQUARINGS;
  localparam int LANE_LAT      = 2 + A_QBITS + 7 + EXP_LAT + 2 + RD_QBITS;

  localparam logic [16:0] C08        = 17'd52429;
  localparam logic [19:0] C19        = 20'd124518;
  localparam logic [23:0] XMAX       = 24'd8388608;
  localparam logic [27:0] INV8PI_Q32 = 28'd170891319;
  localparam logic [31:0] DIV3_MAGIC = 32'hAAAAAAAB;
  localparam logic [31:0] EXP_ONE    = 32'h8000_0000;

  // register map, by word address
  localparam logic REG_ANISOTROPY = 1'b0;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] absorption_red;
    logic [31:0] absorption_green;
    logic [31:0] absorption_blue;
    logic [31:0] scattering_red;
    logic [31:0] scattering_green;
    logic [31:0] scattering_blue;
  } dpe_in_t;

  typedef struct packed {
    logic [31:0] profile_red;
    logic [31:0] profile_green;
    logic [31:0] profile_blue;
  } dpe_out_t;

  // floor(2^33 / n) for the series divisors
  function automatic logic [33:0] exp_recip(input int n);
    logic [33:0] v;
    case (n)
      1:       v = 34'd8589934592;
      2:       v = 34'd4294967296;
      3:       v = 34'd2863311530;
      4:       v = 34'd2147483648;
      5:       v = 34'd1717986918;
      6:       v = 34'd1431655765;
      7:       v = 34'd1227133513;
      8:       v = 34'd1073741824;
      9:       v = 34'd954437176;
      10:      v = 34'd858993459;
      default: v = 34'd0;
    endcase
    return v;
  endfunction

endpackage

### src/dpe_exp.sv
// ----------------------------------------------------------------------------
// dpe_exp: pipelined exp(-y)
// Horner series of exp(-y/256) over ten terms, then eight squarings.
// ----------------------------------------------------------------------------
module dpe_exp import dpe_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] arg,
  output logic [16:0] result
);

  logic [30:0] t0;
  logic [30:0] ta_r [0:EXP_TERMS-1];
  logic [30:0] va_r [0:EXP_TERMS-1];
  logic [30:0] tb_r [0:EXP_TERMS-1];
  logic [30:0] vb_r [0:EXP_TERMS-1];
  logic [30:0] qb_r [0:EXP_TERMS-1];
  logic [30:0] tc_r [0:EXP_TERMS-1];
  logic [31:0] pc_r [0:EXP_TERMS-1];
  logic [31:0] sq_r [0:EXP_SQUARINGS-1];

  assign t0 = {arg, 7'b0};

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int          N   = EXP_TERMS - j;
    localparam logic [33:0] RCP = exp_recip(N);
    localparam logic [3:0]  NC  = 4'(N);
    logic [30:0] t_in;
    logic [31:0] p_in;
    logic [62:0] mprod;
    logic [64:0] rprod;
    logic [34:0] qn;
    logic [34:0] rem;
    logic [30:0] q;

    if (j == 0) begin : g_first
      assign t_in = t0;
      assign p_in = EXP_ONE;
    end else begin : g_next
      assign t_in = tc_r[j-1];
      assign p_in = pc_r[j-1];
    end

    assign mprod = 63'(t_in) * 63'(p_in);
    assign rprod = 65'(va_r[j]) * 65'(RCP);
    assign qn    = 35'(qb_r[j]) * 35'(NC);
    assign rem   = 35'(vb_r[j]) - qn;
    assign q     = (rem >= 35'(NC)) ? qb_r[j] + 31'd1 : qb_r[j];

    always_ff @(posedge clk) begin
      if (en) begin
        ta_r[j] <= t_in;
        va_r[j] <= mprod[61:31];
        tb_r[j] <= ta_r[j];
        vb_r[j] <= va_r[j];
        qb_r[j] <= rprod[63:33];
        tc_r[j] <= tb_r[j];
        pc_r[j] <= EXP_ONE - 32'(q);
      end
    end
  end

  for (genvar k = 0; k < EXP_SQUARINGS; k++) begin : g_sq
    logic [31:0] s_in;
    logic [63:0] sprod;
    if (k == 0) begin : g_first
      assign s_in = pc_r[EXP_TERMS-1];
    end else begin : g_next
      assign s_in = sq_r[k-1];
    end
    assign sprod = 64'(s_in) * 64'(s_in);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= sprod[62:31];
      end
    end
  end

  assign result = sq_r[EXP_SQUARINGS-1][31:15];

endmodule

### src/dpe_lane.sv
// ----------------------------------------------------------------------------
// dpe_lane: one color channel of the diffusion profile
// Albedo divider, scaling, exponent, two exp units and reflectance divider.
// ----------------------------------------------------------------------------
module dpe_lane import dpe_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] aniso,
  input  logic [31:0]        radius,
  input  logic [31:0]        absorption,
  input  logic [31:0]        scattering,
  output logic [31:0]        profile
);

  // reduced scattering
  logic signed [17:0] omg_s;
  logic [16:0]        omg;
  logic [48:0]        ssp_prod;
  logic [32:0]        ssp1_r;
  logic [31:0]        sa1_r, r1_r;

  assign omg_s    = 18'sd32768 - 18'(aniso);
  assign omg      = omg_s[16:0];
  assign ssp_prod = 49'(scattering) * 49'(omg);

  always_ff @(posedge clk) begin
    if (en) begin
      ssp1_r <= ssp_prod[47:15];
      sa1_r  <= absorption;
      r1_r   <= radius;
    end
  end

  // extinction
  logic [33:0] st2_r;
  logic [48:0] num2_r;
  logic [31:0] r2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r  <= 34'(ssp1_r) + 34'(sa1_r);
      num2_r <= {ssp1_r, 16'b0};
      r2_r   <= r1_r;
    end
  end

  // albedo divider
  logic [48:0]        arem_r [1:A_QBITS];
  logic [A_QBITS-1:0] aquo_r [1:A_QBITS];
  logic [33:0]        ast_r  [1:A_QBITS];
  logic [31:0]        ar_r   [1:A_QBITS];

  for (genvar j = 0; j < A_QBITS; j++) begin : g_adiv
    localparam int B = A_QBITS - 1 - j;
    logic [48:0]        rem_in;
    logic [A_QBITS-1:0] quo_in;
    logic [33:0]        st_in;
    logic [31:0]        r_in;
    logic [49:0]        dsh;
    logic               ge;
    if (j == 0) begin : g_first
      assign rem_in = num2_r;
      assign quo_in = '0;
      assign st_in  = st2_r;
      assign r_in   = r2_r;
    end else begin : g_next
      assign rem_in = arem_r[j];
      assign quo_in = aquo_r[j];
      assign st_in  = ast_r[j];
      assign r_in   = ar_r[j];
    end
    assign dsh = 50'(st_in) << B;
    assign ge  = 50'(rem_in) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        arem_r[j+1] <= ge ? 49'(50'(rem_in) - dsh) : rem_in;
        aquo_r[j+1] <= quo_in | (ge ? (A_QBITS'(1) << B) : '0);
        ast_r[j+1]  <= st_in;
        ar_r[j+1]   <= r_in;
      end
    end
  end

  logic [16:0] a19;
  logic [33:0] st19;
  logic [16:0] ad19;
  assign a19  = aquo_r[A_QBITS];
  assign st19 = ast_r[A_QBITS];
  assign ad19 = (a19 >= C08) ? a19 - C08 : C08 - a19;

  // scaling
  logic        zero20_r, zero21_r, zero22_r, zero23_r, zero24_r, zero25_r, zero26_r;
  logic [15:0] ad20_r, sq21_r;
  logic [16:0] a20_r, a21_r, a22_r;
  logic [33:0] st20_r, st21_r, st22_r, st23_r, st24_r;
  logic [31:0] r20_r, r21_r, r22_r, r23_r, r24_r, r25_r, r26_r;
  logic [18:0] s22_r;
  logic [36:0] k23_r;
  logic [19:0] p23_r;
  logic [63:0] pl24_r;
  logic [36:0] ph24_r;
  logic [15:0] q24_r;
  logic [23:0] x25_r, xd26_r;
  logic [33:0] t25_r, t26_r;
  logic [22:0] x326_r;

  logic [31:0] adprod;
  logic [18:0] s7;
  logic [19:0] ssum;
  logic [52:0] kprod;
  logic [35:0] pprod;
  logic [47:0] qprod;
  logic [68:0] kr;
  logic [49:0] tprod;
  logic [55:0] x3prod;

  assign adprod = 32'(ad20_r) * 32'(ad20_r);
  assign s7     = 19'(sq21_r) * 19'd7;
  assign ssum   = C19 + 20'(s7[18:1]) - 20'(a21_r);
  assign kprod  = 53'(s22_r) * 53'(st22_r);
  assign pprod  = 36'(a22_r) * 36'(s22_r);
  assign qprod  = 48'(p23_r) * 48'(INV8PI_Q32);
  assign kr     = {ph24_r, 32'b0} + 69'(pl24_r);
  assign tprod  = 50'(q24_r) * 50'(st24_r);
  assign x3prod = 56'(x25_r) * 56'(DIV3_MAGIC);

  always_ff @(posedge clk) begin
    if (en) begin
      zero20_r <= (st19 == '0) || (a19 == '0);
      ad20_r   <= ad19[15:0];
      a20_r    <= a19;
      st20_r   <= st19;
      r20_r    <= ar_r[A_QBITS];

      sq21_r   <= adprod[31:16];
      a21_r    <= a20_r;
      st21_r   <= st20_r;
      r21_r    <= r20_r;
      zero21_r <= zero20_r;

      s22_r    <= ssum[18:0];
      a22_r    <= a21_r;
      st22_r   <= st21_r;
      r22_r    <= r21_r;
      zero22_r <= zero21_r;

      k23_r    <= kprod[52:16];
      p23_r    <= pprod[35:16];
      st23_r   <= st22_r;
      r23_r    <= r22_r;
      zero23_r <= zero22_r;

      pl24_r   <= 64'(k23_r[31:0]) * 64'(r23_r);
      ph24_r   <= 37'(k23_r[36:32]) * 37'(r23_r);
      q24_r    <= qprod[47:32];
      st24_r   <= st23_r;
      r24_r    <= r23_r;
      zero24_r <= zero23_r;

      x25_r    <= (kr[68:16] > 53'(XMAX)) ? XMAX : kr[39:16];
      t25_r    <= tprod[49:16];
      r25_r    <= r24_r;
      zero25_r <= zero24_r;

      x326_r   <= x3prod[55:33];
      xd26_r   <= x25_r;
      t26_r    <= t25_r;
      r26_r    <= r25_r;
      zero26_r <= zero25_r;
    end
  end

  // exponentials
  logic [16:0] e0, e1;

  dpe_exp u_exp0 (
    .clk    (clk),
    .en     (en),
    .arg    (xd26_r),
    .result (e0)
  );

  dpe_exp u_exp1 (
    .clk    (clk),
    .en     (en),
    .arg    ({1'b0, x326_r}),
    .result (e1)
  );

  logic [33:0] dt_r    [1:EXP_LAT];
  logic [31:0] dr_r    [1:EXP_LAT];
  logic        dzero_r [1:EXP_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dt_r[1]    <= t26_r;
      dr_r[1]    <= r26_r;
      dzero_r[1] <= zero26_r;
      for (int i = 2; i <= EXP_LAT; i++) begin
        dt_r[i]    <= dt_r[i-1];
        dr_r[i]    <= dr_r[i-1];
        dzero_r[i] <= dzero_r[i-1];
      end
    end
  end

  // reflectance numerator
  logic [17:0] esum;
  logic [51:0] uprod;
  logic [35:0] u_r;
  logic [31:0] ru_r, rs_r;
  logic        zu_r, zs_r, sat_r;
  logic [51:0] nums_r;

  assign esum  = 18'(e0) + 18'(e1);
  assign uprod = 52'(dt_r[EXP_LAT]) * 52'(esum);

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= uprod[51:16];
      ru_r   <= dr_r[EXP_LAT];
      zu_r   <= dzero_r[EXP_LAT];

      sat_r  <= 32'(u_r[35:16]) >= ru_r;
      nums_r <= {u_r, 16'b0};
      rs_r   <= ru_r;
      zs_r   <= zu_r;
    end
  end

  // radius divider
  logic [51:0]         rrem_r  [1:RD_QBITS];
  logic [RD_QBITS-1:0] rquo_r  [1:RD_QBITS];
  logic [31:0]         rr_r    [1:RD_QBITS];
  logic                rsat_r  [1:RD_QBITS];
  logic                rzero_r [1:RD_QBITS];

  for (genvar j = 0; j < RD_QBITS; j++) begin : g_rdiv
    localparam int B = RD_QBITS - 1 - j;
    logic [51:0]         rem_in;
    logic [RD_QBITS-1:0] quo_in;
    logic [31:0]         r_in;
    logic                sat_in, zero_in;
    logic [63:0]         dsh;
    logic                ge;
    if (j == 0) begin : g_first
      assign rem_in  = nums_r;
      assign quo_in  = '0;
      assign r_in    = rs_r;
      assign sat_in  = sat_r;
      assign zero_in = zs_r;
    end else begin : g_next
      assign rem_in  = rrem_r[j];
      assign quo_in  = rquo_r[j];
      assign r_in    = rr_r[j];
      assign sat_in  = rsat_r[j];
      assign zero_in = rzero_r[j];
    end
    assign dsh = 64'(r_in) << B;
    assign ge  = 64'(rem_in) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rrem_r[j+1]  <= ge ? 52'(64'(rem_in) - dsh) : rem_in;
        rquo_r[j+1]  <= quo_in | (ge ? (RD_QBITS'(1) << B) : '0);
        rr_r[j+1]    <= r_in;
        rsat_r[j+1]  <= sat_in;
        rzero_r[j+1] <= zero_in;
      end
    end
  end

  assign profile = rzero_r[RD_QBITS] ? '0 :
                   rsat_r[RD_QBITS]  ? '1 : rquo_r[RD_QBITS];

endmodule

### src/diffusion_profile_eval.sv
// ----------------------------------------------------------------------------
// diffusion_profile_eval: normalized subsurface diffusion profile
// Three channel lanes in parallel, merged into one output register.
// ----------------------------------------------------------------------------
// an accepted item passes through the lane pipeline, then the merge register, to out_valid
// throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and stalled
// reset: clears the valid pipeline, out_valid and anisotropy (g = 0);
//   datapath registers are not reset
module diffusion_profile_eval import dpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dpe_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dpe_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [15:0]  aniso_r;
  logic [LANE_LAT-1:0] vld_r;
  logic                out_valid_r;
  dpe_out_t            out_data_r;
  logic                en;
  logic [31:0]         radius;
  logic [31:0]         sa [CHANNELS];
  logic [31:0]         ss [CHANNELS];
  logic [31:0]         rd [CHANNELS];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ANISOTROPY) ? {16'd0, aniso_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aniso_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ANISOTROPY) begin
      aniso_r <= pwdata[15:0];
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign radius   = (in_data.radius == '0) ? 32'd1 : in_data.radius;

  assign sa[0] = in_data.absorption_red;
  assign sa[1] = in_data.absorption_green;
  assign sa[2] = in_data.absorption_blue;
  assign ss[0] = in_data.scattering_red;
  assign ss[1] = in_data.scattering_green;
  assign ss[2] = in_data.scattering_blue;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    dpe_lane u_lane (
      .clk        (clk),
      .en         (en),
      .aniso      (aniso_r),
      .radius     (radius),
      .absorption (sa[c]),
      .scattering (ss[c]),
      .profile    (rd[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LANE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.profile_red   <= rd[0];
      out_data_r.profile_green <= rd[1];
      out_data_r.profile_blue  <= rd[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(vld_r))
    else $error("valid pipeline moved while output blocked");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[LANE_LAT-1]))
    else $error("result without an item at the lane end");
  assert property (@(posedge clk) !rst_n |=> !out_valid_r && vld_r == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule

### bench/diffusion_profile_eval_tb.sv
// ----------------------------------------------------------------------------
// diffusion_profile_eval_tb: self-checking bench for the diffusion profile
// A directed table is run first, then random transfers across several
// anisotropy settings and idle/stall mixes. Typed rows want 0; other accepted
// inputs are scored against a fixed-point model of the three-channel datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module diffusion_profile_eval_tb;
  import dpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct {
    dpe_in_t  stim;
    bit       typed;
    dpe_out_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  dpe_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dpe_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dpe_out_t    profile_queue[$];
  logic signed [15:0] model_g = '0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          transfers_in = 0;
  int          transfers_out = 0;
  int          quiet_cycles = 0;
  int          saturated_seen = 0;
  int          zero_seen = 0;

  diffusion_profile_eval dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] neg_exp_q(logic [63:0] y);
    logic [63:0] t;
    logic [63:0] p;
    if (y > 64'(XMAX)) y = 64'(XMAX);
    t = y << (23 - FRAC_BITS);
    p = 64'(EXP_ONE);
    for (int n = EXP_TERMS; n >= 1; n--)
      p = 64'(EXP_ONE) - ((t * p) >> 31) / 64'(n);
    for (int n = 0; n < EXP_SQUARINGS; n++)
      p = (p * p) >> 31;
    return p >> (31 - FRAC_BITS);
  endfunction

  function automatic logic [31:0] lane_profile(logic [63:0] r, logic [63:0] sa,
                                               logic [63:0] ss);
    logic [63:0] omg, ssp, st, a, ad, sq, s, k, x, e, p, q, tt, u, rd;
    omg = 64'(32768 - int'(model_g));
    ssp = (ss * omg) >> 15;
    st = ssp + sa;
    if (st == 0) return '0;
    a = (ssp << FRAC_BITS) / st;
    if (a == 0) return '0;
    ad = (a >= 64'(C08)) ? a - 64'(C08) : 64'(C08) - a;
    sq = (ad * ad) >> FRAC_BITS;
    s = 64'(C19) + ((64'd7 * sq) >> 1) - a;
    k = (s * st) >> FRAC_BITS;
    if (k != 0 && r > (64'(XMAX) << FRAC_BITS) / k) x = 64'(XMAX);
    else x = (k * r) >> FRAC_BITS;
    if (x > 64'(XMAX)) x = 64'(XMAX);
    e = neg_exp_q(x) + neg_exp_q(x / 3);
    p = (a * s) >> FRAC_BITS;
    q = (p * 64'(INV8PI_Q32)) >> 32;
    tt = (q * st) >> FRAC_BITS;
    u = (tt * e) >> FRAC_BITS;
    rd = (u << FRAC_BITS) / r;
    return (rd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd[31:0];
  endfunction

  function automatic dpe_out_t profile_of(dpe_in_t d);
    dpe_out_t o;
    logic [63:0] r;
    r = (d.radius == 0) ? 64'd1 : 64'(d.radius);
    o.profile_red   = lane_profile(r, 64'(d.absorption_red),   64'(d.scattering_red));
    o.profile_green = lane_profile(r, 64'(d.absorption_green), 64'(d.scattering_green));
    o.profile_blue  = lane_profile(r, 64'(d.absorption_blue),  64'(d.scattering_blue));
    return o;
  endfunction

  // spread magnitudes so small and huge coefficients both show up
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(31);
      2: return $urandom_range(32'h0004_0000);
      3: return $urandom_range(32'h0000_4000);
      4: return 32'h0000_4000 + $urandom_range(32'h0008_0000);
      default: return ($urandom_range(7) == 0) ? 32'h0 : $urandom >> 8;
    endcase
  endfunction

  // valid stays high after a transfer so the next call can follow directly
  task automatic send_transfer(dpe_in_t d, bit typed, dpe_out_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    profile_queue.push_back(typed ? want : profile_of(d));
    transfers_in++;
  endtask

  task automatic write_anisotropy(logic [15:0] g);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {REG_ANISOTROPY, 2'b00};
    pwdata = {16'($urandom_range(16'hFFFF)), g};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_g = g;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== g) begin
      mismatches++;
      if (mismatches <= 10)
        $display("anisotropy readback: expected %h got %h", g, prdata[15:0]);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (profile_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    dpe_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      transfers_out++;
      if (profile_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer %h", out_data);
      end else begin
        want = profile_queue.pop_front();
        if (out_data.profile_red == 32'hFFFF_FFFF) saturated_seen++;
        if (out_data.profile_red == 0) zero_seen++;
        if (out_data.profile_red !== want.profile_red ||
            out_data.profile_green !== want.profile_green ||
            out_data.profile_blue !== want.profile_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("profile mismatch: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                     want.profile_red, want.profile_green, want.profile_blue,
                     out_data.profile_red, out_data.profile_green,
                     out_data.profile_blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d outputs pending", profile_queue.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    dpe_in_t d;
    logic [15:0] g_list[8];

    // zero extinction, zero albedo, radius extremes, saturation, huge exponent
    row.typed = 1'b1; row.want = '0;
    row.stim = '0; rows.push_back(row);
    row.stim = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000, 0, 0, 0};
    rows.push_back(row);
    row.stim = '{0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 0, 0, 0}; rows.push_back(row);
    row.typed = 1'b0;
    row.stim = '{0, 32'h0000_1000, 32'h0001_0000, 32'h0, 32'h0001_0000,
                 32'h0004_0000, 32'h0000_0100}; rows.push_back(row);
    row.stim = '{32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1}; rows.push_back(row);
    row.stim = '{32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                 32'h0010_0000, 32'h0010_0000, 32'h0010_0000}; rows.push_back(row);
    row.stim = '{32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; rows.push_back(row);
    row.stim = '{32'h0000_0100, 32'h0, 32'h0, 32'h0,
                 32'hFFFF_FFFF, 32'h0001_0000, 32'h1}; rows.push_back(row);
    row.stim = '{32'h0000_8000, 32'h0000_1999, 32'h0000_4000, 32'h0001_0000,
                 32'h0000_CCCD, 32'h0001_0000, 32'h0000_4000}; rows.push_back(row);
    row.stim = '{32'h0010_0000, 32'h0000_0400, 32'h0000_0400, 32'h0000_0400,
                 32'h0000_4000, 32'h0000_4000, 32'h0000_4000}; rows.push_back(row);
    row.stim = '{32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0}; rows.push_back(row);
    row.stim = '{32'h0000_0001, 32'h0, 32'h0, 32'h0,
                 32'h0000_0100, 32'h0001_0000, 32'h0100_0000}; rows.push_back(row);

    g_list = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001,
               16'hFFFF, 16'h0000};
    g_list[3] = 16'($urandom_range(16'hFFFF));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_transfer(rows[i].stim, rows[i].typed, rows[i].want);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_anisotropy(g_list[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (phase == 2) foreach (rows[i]) if (!rows[i].typed)
        send_transfer(rows[i].stim, 1'b0, '0);
      for (int n = 0; n < 250; n++) begin
        d.radius = ($urandom_range(9) == 0) ? 32'h0 : rand_coef();
        d.absorption_red = rand_coef();
        d.absorption_green = rand_coef();
        d.absorption_blue = rand_coef();
        d.scattering_red = rand_coef();
        d.scattering_green = rand_coef();
        d.scattering_blue = rand_coef();
        send_transfer(d, 1'b0, '0);
      end
      drain();
    end

    $display("%0d input and %0d output transfers over 8 anisotropy settings",
             transfers_in, transfers_out);
    $display("red lane: %0d zero and %0d saturated results, %0d mismatches",
             zero_seen, saturated_seen, mismatches);
    if (mismatches == 0 && profile_queue.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
src/dpe_pkg.sv
src/dpe_exp.sv
src/dpe_lane.sv
src/diffusion_profile_eval.sv
bench/diffusion_profile_eval_tb.sv
